@@ rtl/lstmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lstmc_pkg;

  typedef struct packed {
    logic               mode;
    logic [1:0]         gate_select;
    logic [4:0]         unit_index;
    logic [6:0]         column_index;
    logic signed [15:0] value;
    logic               sequence_start;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         hidden_unit;
    logic signed [15:0] hidden_value;
    logic signed [15:0] cell_value;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_POST,
    S_EMIT,
    S_COPY
  } state_e;

  typedef enum logic [1:0] {
    PH_BIAS,
    PH_IN,
    PH_REC
  } phase_e;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;

  localparam logic        MODE_WEIGHT  = 1'b0;
  localparam logic        MODE_ELEMENT = 1'b1;

  localparam logic [63:0] FX_ONE = 64'd1 << 60;

  // (a*b) >> 60 in 60 fraction bit fixed point
  function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // unsigned quotient by shift and subtract, only used while building the tables
  function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(2^k / (1 + exp(-a/8192)))
  function automatic logic [15:0] recip_logistic(input logic [16:0][63:0] pw,
                                                 input logic [17:0] a, input int k);
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    e = FX_ONE;
    for (int j = 0; j < 17; j++) begin
      if (a[j]) begin
        e = mul60(e, pw[j]);
      end
    end
    d = (FX_ONE + e) >> 20;
    q = (div64(64'd1 << (41 + k), d) + 64'd1) >> 1;
    return q[15:0];
  endfunction

  // activation table, evaluated at elaboration: sigmoid, or tanh when tanh_sel
  function automatic logic [1023:0][15:0] build_rom(input logic tanh_sel);
    logic [1023:0][15:0] rom;
    logic [16:0][63:0]   pw;
    logic [63:0]         term;
    logic [63:0]         b;
    int                  s;
    int                  m;
    int                  am;
    int                  r;
    int                  val;
    term = FX_ONE;
    b    = FX_ONE;
    for (int k = 1; k < 24; k++) begin
      if (term != 64'd0) begin
        term = div64(term, 64'(k) * 64'd8192);
        if (k[0]) b = b - term;
        else      b = b + term;
      end
    end
    pw[0] = b;
    for (int k = 1; k < 17; k++) begin
      pw[k] = mul60(pw[k-1], pw[k-1]);
    end
    for (int idx = 0; idx < 1024; idx++) begin
      s  = idx * 64 - ((idx >= 512) ? 65536 : 0);
      m  = 2 * s + 63;
      am = (m < 0) ? -m : m;
      if (tanh_sel) begin
        r   = int'(recip_logistic(pw, 18'(2 * am), 13)) - 4096;
        val = (m > 0) ? r : -r;
      end else begin
        r   = int'(recip_logistic(pw, 18'(am), 12));
        val = (m > 0) ? r : 4096 - r;
      end
      rom[idx] = val[15:0];
    end
    return rom;
  endfunction

  localparam logic [1023:0][15:0] SIG_ROM  = build_rom(1'b0);
  localparam logic [1023:0][15:0] TANH_ROM = build_rom(1'b1);

  // floor((v + 2048) / 4096), saturated to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v);
    logic signed [47:0] w;
    w = (v + 48'sd2048) >>> 12;
    if (w > 48'sd32767) begin
      return 16'sh7fff;
    end else if (w < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return w[15:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/lstmc_wmem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// weight rows, one lane per gate so all four gates are read in one access
module lstmc_wmem #(
  parameter int DEPTH = 3104,
  parameter int AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [1:0]       wlane_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [3:0][15:0] rdata_o
);

  logic [3:0][15:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wlane_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lstmc_act.sv @@
`timescale 1ns / 1ps
`default_nettype none
// activations and cell update, six register stages
module lstmc_act (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [3:0][39:0]    acc_i,
  input  logic signed [15:0]  cprev_i,
  output logic signed [15:0]  c_o,
  output logic signed [15:0]  h_o,
  output logic                done_o
);

  logic [5:0]         vld_q;
  logic signed [15:0] ig_q, fg_q, cg_q, og_q, cp_q;
  logic signed [15:0] og2_q, og3_q, og4_q;
  logic signed [31:0] pi_q, pf_q;
  logic signed [15:0] c_q, t_q;
  logic signed [31:0] ph_q;
  logic signed [15:0] h_q;
  logic [3:0][15:0]   pre;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      pre[g] = lstmc_pkg::rnd_sat(48'(signed'(acc_i[g])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ig_q <= lstmc_pkg::SIG_ROM[pre[0][15:6]];
      fg_q <= lstmc_pkg::SIG_ROM[pre[1][15:6]];
      cg_q <= lstmc_pkg::TANH_ROM[pre[2][15:6]];
      og_q <= lstmc_pkg::SIG_ROM[pre[3][15:6]];
      cp_q <= cprev_i;
    end
    if (vld_q[0]) begin
      pi_q  <= ig_q * cg_q;
      pf_q  <= fg_q * cp_q;
      og2_q <= og_q;
    end
    if (vld_q[1]) begin
      c_q   <= lstmc_pkg::rnd_sat(48'(pi_q) + 48'(pf_q));
      og3_q <= og2_q;
    end
    if (vld_q[2]) begin
      t_q   <= lstmc_pkg::TANH_ROM[c_q[15:6]];
      og4_q <= og3_q;
    end
    if (vld_q[3]) begin
      ph_q <= og4_q * t_q;
    end
    if (vld_q[4]) begin
      h_q <= lstmc_pkg::rnd_sat(48'(ph_q));
    end
  end

  assign c_o    = c_q;
  assign h_o    = h_q;
  assign done_o = vld_q[5];

endmodule
`default_nettype wire

@@ rtl/lstm_cell_forward.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lstm cell, inference only, Q4.12 throughout
// input channel (in_valid_i / in_stall_o): one beat is either a weight or bias
// write (mode 0) or one element of the input vector (mode 1). weight beats go
// straight into the weight memory. the element that completes a time step
// starts the update; in_stall_o stays high until the whole step is done.
// per hidden unit the four gate rows are read together from the weight
// memory, one column a cycle: the bias column, input_count input columns and,
// unless the step starts a sequence, hidden_count recurrent columns; then drain,
// activation, cell update and output load follow. after the last unit the new h
// of every unit is copied from the new-h buffer into the h buffer.
// output channel (out_valid_o / out_stall_i): one beat per hidden unit, unit 0
// first, last on the final unit. a stalled beat holds in its output register;
// the next unit is computed meanwhile and waits to load until the beat leaves.
// config port: cfg_ready_o is always high; write only while idle.
// reset: counts return to their maxima, h and c read as zero, the next step
// acts as a sequence start. weight and input buffer contents are not cleared.
module lstm_cell_forward #(
  parameter int INPUT_MAX  = 64,
  parameter int HIDDEN_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lstmc_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lstmc_pkg::out_item_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [6:0]            cfg_data_i
);

  localparam int ROW_LEN = INPUT_MAX + HIDDEN_MAX + 1;
  localparam int WDEPTH  = HIDDEN_MAX * ROW_LEN;
  localparam int WAW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int IW      = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
  localparam int CW      = $clog2(INPUT_MAX + 1);
  localparam int HW      = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
  localparam int HCW     = $clog2(HIDDEN_MAX + 1);
  localparam int KW      = (CW > HCW) ? CW : HCW;

  lstmc_pkg::state_e state_q, state_d;
  lstmc_pkg::phase_e phase_q;

  logic [6:0]     icnt_q;
  logic [5:0]     hcnt_q;
  logic [CW-1:0]  ic_eff;
  logic [HCW-1:0] hc_eff;

  logic [CW-1:0]  cnt_q;
  logic [CW-1:0]  cnt_inc;
  logic           pend_q;
  logic           zero_q;
  logic [HCW-1:0] j_q;
  logic [KW-1:0]  k_q;

  logic           in_acc;
  logic           elem_acc;
  logic           step_fire;
  logic           issue;
  logic           issue_last;
  logic           unit_last;
  logic           act_start;
  logic           out_load;
  logic           cp_rd;

  // memories
  logic signed [15:0] ibuf_mem [INPUT_MAX];
  logic signed [15:0] h_mem    [HIDDEN_MAX];
  logic signed [15:0] nh_mem   [HIDDEN_MAX];
  logic signed [15:0] c_mem    [HIDDEN_MAX];
  logic [HIDDEN_MAX-1:0] hv_q;
  logic [HIDDEN_MAX-1:0] cv_q;

  // weight memory ports
  logic             w_we;
  logic [WAW-1:0]   w_waddr;
  logic [WAW-1:0]   w_raddr;
  logic [3:0][15:0] w_rd;
  int               col;

  // mac pipeline
  logic               vld1_q, vld2_q;
  logic               bias1_q, in1_q, hval1_q;
  logic signed [15:0] ibuf_rd_q, h_rd_q, c_rd_q;
  logic signed [15:0] xop;
  logic [3:0][39:0]   prod_d, prod_q, acc_q;

  logic signed [15:0] act_c, act_h, cprev;
  logic               act_done;

  logic               cp_vld_q;
  logic [HW-1:0]      cp_addr_q;
  logic signed [15:0] nh_rd_q;

  lstmc_pkg::out_item_t out_q;
  logic                 out_vld_q;

  assign cfg_ready_o = 1'b1;

  // effective counts: zero acts as one, large values clip at the maximum
  always_comb begin
    if (icnt_q == 7'd0) begin
      ic_eff = CW'(1);
    end else if (32'(icnt_q) > INPUT_MAX) begin
      ic_eff = CW'(INPUT_MAX);
    end else begin
      ic_eff = CW'(icnt_q);
    end
    if (hcnt_q == 6'd0) begin
      hc_eff = HCW'(1);
    end else if (32'(hcnt_q) > HIDDEN_MAX) begin
      hc_eff = HCW'(HIDDEN_MAX);
    end else begin
      hc_eff = HCW'(hcnt_q);
    end
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign elem_acc  = in_acc && (in_data_i.mode == lstmc_pkg::MODE_ELEMENT);
  assign cnt_inc   = CW'(cnt_q + 1'b1);
  assign step_fire = elem_acc && (cnt_inc >= ic_eff);
  assign unit_last = (j_q == hc_eff - 1'b1);
  assign issue_last = ((phase_q == lstmc_pkg::PH_IN) && (k_q == KW'(ic_eff) - 1'b1) && zero_q)
                   || ((phase_q == lstmc_pkg::PH_REC) && (k_q == KW'(hc_eff) - 1'b1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lstmc_pkg::S_IDLE:  if (step_fire) state_d = lstmc_pkg::S_RUN;
      lstmc_pkg::S_RUN:   if (issue_last) state_d = lstmc_pkg::S_DRAIN;
      lstmc_pkg::S_DRAIN: if (!vld1_q && !vld2_q) state_d = lstmc_pkg::S_POST;
      lstmc_pkg::S_POST:  if (act_done) state_d = lstmc_pkg::S_EMIT;
      lstmc_pkg::S_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = unit_last ? lstmc_pkg::S_COPY : lstmc_pkg::S_RUN;
        end
      end
      lstmc_pkg::S_COPY:  if (unit_last) state_d = lstmc_pkg::S_IDLE;
      default:            state_d = lstmc_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    act_start  = 1'b0;
    out_load   = 1'b0;
    cp_rd      = 1'b0;
    unique case (state_q)
      lstmc_pkg::S_IDLE:  in_stall_o = 1'b0;
      lstmc_pkg::S_RUN:   issue = 1'b1;
      lstmc_pkg::S_DRAIN: act_start = !vld1_q && !vld2_q;
      lstmc_pkg::S_POST:  ;
      lstmc_pkg::S_EMIT:  out_load = !out_vld_q || !out_stall_i;
      lstmc_pkg::S_COPY:  cp_rd = 1'b1;
      default:            ;
    endcase
  end

  // weight memory addressing
  always_comb begin
    unique case (phase_q)
      lstmc_pkg::PH_BIAS: col = ROW_LEN - 1;
      lstmc_pkg::PH_IN:   col = int'(k_q);
      lstmc_pkg::PH_REC:  col = INPUT_MAX + int'(k_q);
      default:            col = ROW_LEN - 1;
    endcase
    w_raddr = WAW'(int'(j_q) * ROW_LEN + col);
    w_waddr = WAW'(int'(in_data_i.unit_index) * ROW_LEN + int'(in_data_i.column_index));
    w_we    = in_acc && (in_data_i.mode == lstmc_pkg::MODE_WEIGHT)
           && (int'(in_data_i.unit_index) < HIDDEN_MAX)
           && (int'(in_data_i.column_index) < ROW_LEN);
  end

  lstmc_wmem #(
    .DEPTH (WDEPTH),
    .AW    (WAW)
  ) u_wmem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wlane_i (in_data_i.gate_select),
    .wdata_i (in_data_i.value),
    .re_i    (issue),
    .raddr_i (w_raddr),
    .rdata_o (w_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lstmc_pkg::S_IDLE;
      phase_q   <= lstmc_pkg::PH_BIAS;
      icnt_q    <= 7'(INPUT_MAX);
      hcnt_q    <= 6'(HIDDEN_MAX);
      cnt_q     <= '0;
      pend_q    <= 1'b1;
      zero_q    <= 1'b0;
      j_q       <= '0;
      k_q       <= '0;
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      cp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hv_q      <= '0;
      cv_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lstmc_pkg::CFG_INPUT_COUNT:  icnt_q <= cfg_data_i;
          lstmc_pkg::CFG_HIDDEN_COUNT: hcnt_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (elem_acc) begin
        if (step_fire) begin
          cnt_q   <= '0;
          zero_q  <= pend_q || in_data_i.sequence_start;
          pend_q  <= 1'b0;
          j_q     <= '0;
          k_q     <= '0;
          phase_q <= lstmc_pkg::PH_BIAS;
        end else begin
          cnt_q  <= cnt_inc;
          pend_q <= pend_q || in_data_i.sequence_start;
        end
      end
      if (issue) begin
        case (phase_q)
          lstmc_pkg::PH_BIAS: begin
            phase_q <= lstmc_pkg::PH_IN;
            k_q     <= '0;
          end
          lstmc_pkg::PH_IN: begin
            if (k_q == KW'(ic_eff) - 1'b1) begin
              phase_q <= lstmc_pkg::PH_REC;
              k_q     <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
          default: k_q <= k_q + 1'b1;
        endcase
      end
      vld1_q <= issue;
      vld2_q <= vld1_q;
      if (out_load) begin
        cv_q[j_q[HW-1:0]] <= 1'b1;
        phase_q <= lstmc_pkg::PH_BIAS;
        j_q     <= unit_last ? '0 : j_q + 1'b1;
      end
      if (cp_rd) begin
        j_q <= j_q + 1'b1;
      end
      cp_vld_q <= cp_rd;
      if (cp_vld_q) begin
        hv_q[cp_addr_q] <= 1'b1;
      end
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
    end
  end

  // buffers
  always_ff @(posedge clk_i) begin
    if (elem_acc && (int'(cnt_q) < INPUT_MAX)) begin
      ibuf_mem[cnt_q[IW-1:0]] <= in_data_i.value;
    end
    if (issue) begin
      ibuf_rd_q <= ibuf_mem[k_q[IW-1:0]];
      h_rd_q    <= h_mem[k_q[HW-1:0]];
      hval1_q   <= hv_q[k_q[HW-1:0]];
      bias1_q   <= (phase_q == lstmc_pkg::PH_BIAS);
      in1_q     <= (phase_q == lstmc_pkg::PH_IN);
    end
    if (issue && (phase_q == lstmc_pkg::PH_BIAS)) begin
      c_rd_q <= c_mem[j_q[HW-1:0]];
    end
    if (out_load) begin
      c_mem[j_q[HW-1:0]]  <= act_c;
      nh_mem[j_q[HW-1:0]] <= act_h;
    end
    if (cp_rd) begin
      nh_rd_q   <= nh_mem[j_q[HW-1:0]];
      cp_addr_q <= j_q[HW-1:0];
    end
    if (cp_vld_q) begin
      h_mem[cp_addr_q] <= nh_rd_q;
    end
  end

  // multiply stage, then accumulate; bias enters shifted up by 12
  always_comb begin
    xop = in1_q ? ibuf_rd_q : (hval1_q ? h_rd_q : 16'sd0);
    for (int g = 0; g < 4; g++) begin
      if (bias1_q) begin
        prod_d[g] = 40'(signed'(w_rd[g])) <<< 12;
      end else begin
        prod_d[g] = 40'(signed'(w_rd[g]) * xop);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      prod_q <= prod_d;
    end
    for (int g = 0; g < 4; g++) begin
      if (issue && (phase_q == lstmc_pkg::PH_BIAS)) begin
        acc_q[g] <= '0;
      end else if (vld2_q) begin
        acc_q[g] <= acc_q[g] + prod_q[g];
      end
    end
  end

  assign cprev = (zero_q || !cv_q[j_q[HW-1:0]]) ? 16'sd0 : c_rd_q;

  lstmc_act u_act (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (act_start),
    .acc_i   (acc_q),
    .cprev_i (cprev),
    .c_o     (act_c),
    .h_o     (act_h),
    .done_o  (act_done)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.hidden_unit  <= 5'(j_q);
      out_q.hidden_value <= act_h;
      out_q.cell_value   <= act_c;
      out_q.last         <= unit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_done_in_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_done |-> state_q == lstmc_pkg::S_POST)
    else $error("activation result outside post state");

  a_copy_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lstmc_pkg::S_COPY |-> !vld1_q && !vld2_q)
    else $error("mac pipeline busy during copy");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lstmc_pkg::S_RUN |-> j_q < hc_eff)
    else $error("unit index beyond hidden count");

  a_mac_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> $past(vld1_q))
    else $error("accumulate without a read");

endmodule
`default_nettype wire

@@ tb/sv/lstm_checker.sv @@
`timescale 1ns / 1ps
module lstm_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  lstmc_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  lstmc_pkg::out_item_t out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int NIN    = 64;
  localparam int NHID   = 32;
  localparam int BIAS_COL = NIN + NHID;
  localparam logic [63:0] UNITY = 64'd1 << 60;

  logic [63:0] exp_pow [17];
  int sig_tab [1024];
  int tanh_tab [1024];

  logic signed [15:0] weights [4][NHID][BIAS_COL + 1];
  logic signed [15:0] x_buf [NIN];
  logic signed [15:0] h_prev [NHID];
  logic signed [15:0] h_next [NHID];
  logic signed [15:0] c_state [NHID];
  int unsigned elem_cnt;
  bit  seq_mark;
  int unsigned in_count_reg;
  int unsigned hid_count_reg;

  lstmc_pkg::out_item_t hidden_results_q [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = hidden_results_q.size();

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // round(2^k / (1 + exp(-a/8192)))
  function automatic int logistic_q(input logic [17:0] a, input int k);
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    e = UNITY;
    for (int j = 0; j < 17; j++) begin
      if (a[j]) e = fx_mul(e, exp_pow[j]);
    end
    d = (UNITY + e) >> 20;
    q = (((64'd1 << (41 + k)) / d) + 64'd1) >> 1;
    return int'(q);
  endfunction

  initial begin
    logic [63:0] term;
    logic [63:0] base;
    int k;
    int s;
    int m;
    int am;
    int r;
    term = UNITY;
    base = UNITY;
    k = 1;
    // exp(-1/8192) by its series
    while (term != 64'd0) begin
      term = term / (64'(k) * 64'd8192);
      if (k % 2 == 1) base = base - term;
      else base = base + term;
      k++;
    end
    exp_pow[0] = base;
    for (int i = 1; i < 17; i++) exp_pow[i] = fx_mul(exp_pow[i-1], exp_pow[i-1]);
    for (int idx = 0; idx < 1024; idx++) begin
      s  = idx * 64 - ((idx >= 512) ? 65536 : 0);
      m  = 2 * s + 63;
      am = (m < 0) ? -m : m;
      r  = logistic_q(18'(am), 12);
      sig_tab[idx] = (m > 0) ? r : 4096 - r;
      r  = logistic_q(18'(2 * am), 13) - 4096;
      tanh_tab[idx] = (m > 0) ? r : -r;
    end
  end

  function automatic int sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic longint round_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic int lut_idx(input int v);
    logic [15:0] b;
    b = v[15:0];
    return int'(b[15:6]);
  endfunction

  function automatic int gate_preact(input int g, input int j, input int ic, input int hc,
                                     input bit zero_prev);
    longint acc;
    logic signed [39:0] acc40;
    acc = longint'(weights[g][j][BIAS_COL]) * 4096;
    for (int k = 0; k < ic; k++) acc += longint'(weights[g][j][k]) * longint'(x_buf[k]);
    if (!zero_prev) begin
      for (int k = 0; k < hc; k++) acc += longint'(weights[g][j][NIN + k]) * longint'(h_prev[k]);
    end
    acc40 = acc[39:0];
    return sat16(round_q12(longint'(acc40)));
  endfunction

  task automatic predict_step(input lstmc_pkg::in_item_t it);
    int ic;
    int hc;
    bit zp;
    int ig;
    int fg;
    int cg;
    int og;
    int cp;
    int c;
    int h;
    lstmc_pkg::out_item_t r;
    if (it.mode == lstmc_pkg::MODE_WEIGHT) begin
      if (it.column_index <= BIAS_COL)
        weights[it.gate_select][it.unit_index][it.column_index] = it.value;
      return;
    end
    if (it.sequence_start) seq_mark = 1'b1;
    if (elem_cnt < NIN) x_buf[elem_cnt] = it.value;
    elem_cnt++;
    ic = (in_count_reg == 0) ? 1 : ((in_count_reg > NIN) ? NIN : in_count_reg);
    if (elem_cnt < ic) return;
    elem_cnt = 0;
    hc = (hid_count_reg == 0) ? 1 : ((hid_count_reg > NHID) ? NHID : hid_count_reg);
    zp = seq_mark;
    seq_mark = 1'b0;
    for (int j = 0; j < hc; j++) begin
      ig = sig_tab[lut_idx(gate_preact(0, j, ic, hc, zp))];
      fg = sig_tab[lut_idx(gate_preact(1, j, ic, hc, zp))];
      cg = tanh_tab[lut_idx(gate_preact(2, j, ic, hc, zp))];
      og = sig_tab[lut_idx(gate_preact(3, j, ic, hc, zp))];
      cp = zp ? 0 : int'(c_state[j]);
      c  = sat16(round_q12(longint'(ig) * cg + longint'(fg) * cp));
      h  = sat16(round_q12(longint'(og) * tanh_tab[lut_idx(c)]));
      c_state[j] = c[15:0];
      h_next[j]  = h[15:0];
      r.hidden_unit  = j[4:0];
      r.hidden_value = h[15:0];
      r.cell_value   = c[15:0];
      r.last         = (j == hc - 1);
      hidden_results_q.push_back(r);
    end
    for (int j = 0; j < hc; j++) h_prev[j] = h_next[j];
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    lstmc_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int j = 0; j < NHID; j++) begin
        h_prev[j]  = '0;
        h_next[j]  = '0;
        c_state[j] = '0;
      end
      elem_cnt      = 0;
      seq_mark      = 1'b1;
      in_count_reg  = NIN;
      hid_count_reg = NHID;
      hidden_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == lstmc_pkg::CFG_INPUT_COUNT) in_count_reg = cfg_data_i;
        else if (cfg_index_i == lstmc_pkg::CFG_HIDDEN_COUNT) hid_count_reg = cfg_data_i[5:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (hidden_results_q.size() == 0) begin
          report("unexpected beat, unit", out_data_i.hidden_unit, -1);
        end else begin
          want = hidden_results_q.pop_front();
          if (out_data_i.hidden_unit != want.hidden_unit)
            report("hidden_unit", out_data_i.hidden_unit, want.hidden_unit);
          if (out_data_i.hidden_value != want.hidden_value)
            report("hidden_value", out_data_i.hidden_value, want.hidden_value);
          if (out_data_i.cell_value != want.cell_value)
            report("cell_value", out_data_i.cell_value, want.cell_value);
          if (out_data_i.last != want.last)
            report("last", out_data_i.last, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) predict_step(in_data_i);
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  // counts stay within the rows and columns written below
  localparam int IC_TOP = 8;
  localparam int HC_TOP = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  lstmc_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  lstmc_pkg::out_item_t out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i;
  logic [6:0]           cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   burst_left;
  bit                   hold_req;
  bit                   hold_done;

  lstm_cell_forward uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  lstm_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #30ms;
    $display("lstm_cell_forward regression: fail");
    $finish;
  end

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic lstmc_pkg::in_item_t weight_beat(input int g, input int u, input int col,
                                                      input logic [15:0] v);
    lstmc_pkg::in_item_t it;
    it.mode           = lstmc_pkg::MODE_WEIGHT;
    it.gate_select    = g[1:0];
    it.unit_index     = u[4:0];
    it.column_index   = col[6:0];
    it.value          = v;
    it.sequence_start = 1'($urandom);
    return it;
  endfunction

  function automatic lstmc_pkg::in_item_t element_beat(input logic [15:0] v, input bit ss);
    lstmc_pkg::in_item_t it;
    it                = lstmc_pkg::in_item_t'($urandom);
    it.mode           = lstmc_pkg::MODE_ELEMENT;
    it.value          = v;
    it.sequence_start = ss;
    return it;
  endfunction

  // beats go out in bursts; valid stays high between beats of one burst
  task automatic send_beat(input lstmc_pkg::in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (--burst_left <= 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender quiet until every step has emptied out, plus the copy of h
  task automatic drain();
    stop_sending();
    wait (pending == 0);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_counts(input logic [6:0] ic, input logic [6:0] hc);
    drain();
    write_reg(lstmc_pkg::CFG_INPUT_COUNT, ic);
    write_reg(lstmc_pkg::CFG_HIDDEN_COUNT, hc);
  endtask

  task automatic run_elements(input int n, input int weight_odds);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, weight_odds) == 1)
        send_beat(weight_beat($urandom_range(0, 3), $urandom, $urandom_range(0, 127),
                              rand_value()));
      send_beat(element_beat(rand_value(), $urandom_range(0, 7) == 0));
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int era_kind;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      era_kind = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        if (hold_req && !hold_done) begin
          out_stall_i <= 1'b1;
          repeat (2999) @(negedge clk_i);
          hold_done = 1'b1;
        end else begin
          case (era_kind)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= 1'($urandom);
            default: out_stall_i <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = lstmc_pkg::CFG_INPUT_COUNT;
    cfg_data_i  = '0;
    hold_req    = 1'b0;
    burst_left  = 4;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the weights and biases of every row and column the counts can reach
    for (int g = 0; g < 4; g++)
      for (int u = 0; u < HC_TOP; u++)
        for (int col = 0; col <= 96; col++)
          if (col < IC_TOP || (col >= 64 && col < 64 + HC_TOP) || col == 96)
            send_beat(weight_beat(g, u, col, rand_value()));

    // extremes and ignored addresses
    send_beat(weight_beat(3, 31, 96, 16'h7fff));
    send_beat(weight_beat(0, 0, 96, 16'h8000));
    send_beat(weight_beat(1, 0, 0, 16'h7fff));
    send_beat(weight_beat(2, 0, 64, 16'h8000));
    send_beat(weight_beat(2, 5, 97, 16'h1234));
    send_beat(weight_beat(1, 31, 127, 16'hffff));
    set_counts(7'd1, 7'd1);
    send_beat(element_beat(16'h8000, 1'b1));
    send_beat(element_beat(16'h7fff, 1'b0));
    send_beat(element_beat(16'h0000, 1'b0));
    send_beat(element_beat(16'hffff, 1'b1));
    set_counts(7'd0, 7'd0);
    send_beat(element_beat(16'h7fff, 1'b0));
    send_beat(element_beat(16'h8000, 1'b1));

    // widest setting in use, two full steps
    set_counts(7'(IC_TOP), 7'(HC_TOP));
    send_beat(element_beat(rand_value(), 1'b1));
    run_elements(2 * IC_TOP - 1, 1000);
    // lowering the count mid-step closes the step on the next element
    run_elements(3, 1000);
    set_counts(7'd2, 7'(HC_TOP));
    send_beat(element_beat(rand_value(), 1'b0));

    for (int p = 0; p < 12; p++) begin
      set_counts($urandom_range(1, IC_TOP), (p == 5) ? 7'(HC_TOP) : $urandom_range(1, HC_TOP));
      if (p == 3) hold_req = 1'b1;
      run_elements($urandom_range(4, 8), 6);
      if (p == 7) begin
        drain();
        run_elements(6, 6);
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("lstm_cell_forward regression: pass");
    end else begin
      $display("lstm_cell_forward regression: fail");
    end
    $finish;
  end

endmodule
